### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, sampled on clk, off while rst_n is low
`define KPPL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check that also holds during reset
`define KPPL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/kppl_pkg.sv
`default_nettype none

package kppl_pkg;

    localparam int KEY_W   = 8;
    localparam int PIN_W   = 32;
    localparam int TRIES_W = 4;
    localparam int TICKS_W = 16;
    localparam int DIGIT_W = 3;
    localparam int ROLE_W  = 2;
    localparam int IDX_W   = 3;

    typedef enum logic [1:0] {
        PH_SELECT = 2'd0,
        PH_ENTRY  = 2'd1,
        PH_LOCKED = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_WRONG_SEL = 3'd1,
        ST_ROLE      = 3'd2,
        ST_DIGIT     = 3'd3,
        ST_GRANTED   = 3'd4,
        ST_WRONG_PIN = 3'd5,
        ST_LOCKED    = 3'd6,
        ST_LOCK_END  = 3'd7
    } status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_ADMIN_PIN     = 3'd0,
        REG_GUEST_PIN     = 3'd1,
        REG_ADMIN_SEL     = 3'd2,
        REG_GUEST_SEL     = 3'd3,
        REG_FAIL_LIMIT    = 3'd4,
        REG_BLOCK_TICKS   = 3'd5,
        REG_START_BLOCKED = 3'd6
    } reg_idx_t;

    localparam logic [ROLE_W-1:0] ROLE_NONE  = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_ADMIN = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_GUEST = 2'd2;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
    } item_t;

    typedef struct packed {
        logic [PIN_W-1:0]   admin_pin;
        logic [PIN_W-1:0]   guest_pin;
        logic [KEY_W-1:0]   admin_select_key;
        logic [KEY_W-1:0]   guest_select_key;
        logic [TRIES_W-1:0] fail_limit;
        logic [TICKS_W-1:0] block_ticks;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic [ROLE_W-1:0]  granted_role;
        logic [TRIES_W-1:0] tries_left;
        logic [DIGIT_W-1:0] digits_entered;
    } res_t;

endpackage

`default_nettype wire

### sv/kppl_core.sv
`default_nettype none

module kppl_core
    import kppl_pkg::*;
#(
    parameter int PIN_LENGTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  run,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    input  wire logic  lock_load,
    output res_t       res
);

    phase_t             ph_reg, ph_next;
    logic               role_reg, role_next;
    logic [DIGIT_W-1:0] cnt_reg, cnt_next;
    logic [TRIES_W-1:0] failed_reg, failed_next;
    logic [TICKS_W-1:0] cd_reg, cd_next;
    logic [KEY_W-1:0]   pin_reg [PIN_LENGTH];
    logic [KEY_W-1:0]   pin_next [PIN_LENGTH];

    logic               is_tick;
    logic               in_lock;
    logic               in_entry;
    logic               hit_admin;
    logic               hit_guest;
    logic [DIGIT_W-1:0] cnt_inc;
    logic               last_digit;
    logic [PIN_W-1:0]   want;
    logic               match;
    logic [TRIES_W-1:0] fail_inc;
    logic               fail_lock;
    logic               tick_end;
    logic               key_entry;

    assign is_tick    = item.action;
    assign in_lock    = (ph_reg == PH_LOCKED);
    assign in_entry   = (ph_reg == PH_ENTRY);
    assign hit_admin  = (item.key == cfg.admin_select_key);
    assign hit_guest  = (item.key == cfg.guest_select_key);
    assign cnt_inc    = cnt_reg + 3'd1;
    assign last_digit = (cnt_inc >= DIGIT_W'(PIN_LENGTH));
    assign want       = role_reg ? cfg.guest_pin : cfg.admin_pin;
    assign fail_inc   = failed_reg + 4'd1;
    assign fail_lock  = (fail_inc >= cfg.fail_limit);
    assign tick_end   = (cd_reg <= 16'd1);
    assign key_entry  = run && !is_tick && in_entry;

    // digit capture and compare against the chosen role's pin
    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < PIN_LENGTH; i++)
        begin
            pin_next[i] = (key_entry && cnt_reg == DIGIT_W'(i)) ? item.key : pin_reg[i];
            match       = match && (pin_next[i] == want[8*i +: 8]);
        end
    end

    // next state
    always_comb
    begin
        ph_next     = ph_reg;
        role_next   = role_reg;
        cnt_next    = cnt_reg;
        failed_next = failed_reg;
        cd_next     = cd_reg;
        if (lock_load)
        begin
            ph_next  = PH_LOCKED;
            cd_next  = cfg.block_ticks;
            cnt_next = '0;
        end
        else if (run)
        begin
            if (is_tick)
            begin
                if (in_lock)
                begin
                    if (tick_end)
                    begin
                        cd_next     = '0;
                        failed_next = '0;
                        ph_next     = PH_SELECT;
                    end
                    else
                    begin
                        cd_next = cd_reg - 16'd1;
                    end
                end
            end
            else if (in_entry)
            begin
                cnt_next = cnt_inc;
                if (last_digit)
                begin
                    cnt_next = '0;
                    if (match)
                    begin
                        failed_next = '0;
                        ph_next     = PH_SELECT;
                    end
                    else
                    begin
                        failed_next = fail_inc;
                        if (fail_lock)
                        begin
                            ph_next = PH_LOCKED;
                            cd_next = cfg.block_ticks;
                        end
                    end
                end
            end
            else if (!in_lock)
            begin
                if (hit_admin || hit_guest)
                begin
                    role_next = !hit_admin;
                    ph_next   = PH_ENTRY;
                    cnt_next  = '0;
                end
            end
        end
    end

    // result fields
    always_comb
    begin
        priority if (is_tick)
        begin
            res.status = (in_lock && tick_end) ? ST_LOCK_END : ST_NONE;
        end
        else if (in_lock)
        begin
            res.status = ST_LOCKED;
        end
        else if (in_entry)
        begin
            if (!last_digit)
            begin
                res.status = ST_DIGIT;
            end
            else if (match)
            begin
                res.status = ST_GRANTED;
            end
            else
            begin
                res.status = fail_lock ? ST_LOCKED : ST_WRONG_PIN;
            end
        end
        else
        begin
            res.status = (hit_admin || hit_guest) ? ST_ROLE : ST_WRONG_SEL;
        end
        if (res.status == ST_GRANTED)
        begin
            res.granted_role = role_reg ? ROLE_GUEST : ROLE_ADMIN;
        end
        else
        begin
            res.granted_role = ROLE_NONE;
        end
        res.tries_left     = (failed_next >= cfg.fail_limit) ? '0
                           : cfg.fail_limit - failed_next;
        res.digits_entered = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg     <= PH_SELECT;
            role_reg   <= 1'b0;
            cnt_reg    <= '0;
            failed_reg <= '0;
            cd_reg     <= '0;
        end
        else
        begin
            ph_reg     <= ph_next;
            role_reg   <= role_next;
            cnt_reg    <= cnt_next;
            failed_reg <= failed_next;
            cd_reg     <= cd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PIN_LENGTH; i++)
        begin
            pin_reg[i] <= pin_next[i];
        end
    end

endmodule

`default_nettype wire

### sv/keypad_pin_lock_with_lockout.sv
// channel  | dir | handshake           | payload
// s_       | in  | s_tvalid / s_tready | s_tuser action, s_tdata key
// m_       | out | m_tvalid / m_tready | m_tuser status, m_tdata role, tries, digits
// cfg_     | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// one event per cycle sustained while m_tready is high; each event passes the input register then the result register
// the lock state and the pin compare settle in the single stage between them
// reset leaves the block in select with all counts cleared and config registers at defaults
// a stalled result holds m_ and the input register still takes one more request
// cfg_ready is always high

`default_nettype none

module keypad_pin_lock_with_lockout
    import kppl_pkg::*;
#(
    parameter int PIN_LENGTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [KEY_W-1:0]  s_tdata,   // key
    input  wire logic              s_tuser,   // action

    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // granted_role, tries_left, digits_entered, zeros
    output logic [2:0]             m_tuser,   // status

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [PIN_W-1:0]  cfg_data
);

    cfg_t  cfg_reg;
    logic  in_vld_reg;
    item_t in_item_reg;
    logic  out_vld_reg;
    res_t  out_res_reg;
    res_t  res;
    logic  advance;
    logic  cfg_wr;
    logic  lock_load;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign lock_load = cfg_wr && (reg_idx_t'(cfg_index) == REG_START_BLOCKED) && cfg_data[0];

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {7'd0, out_res_reg.digits_entered, out_res_reg.tries_left,
                       out_res_reg.granted_role};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.admin_pin        <= '0;
            cfg_reg.guest_pin        <= '0;
            cfg_reg.admin_select_key <= 8'd48;
            cfg_reg.guest_select_key <= 8'd49;
            cfg_reg.fail_limit       <= 4'd3;
            cfg_reg.block_ticks      <= 16'd20000;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_ADMIN_PIN:     cfg_reg.admin_pin        <= cfg_data;
                REG_GUEST_PIN:     cfg_reg.guest_pin        <= cfg_data;
                REG_ADMIN_SEL:     cfg_reg.admin_select_key <= cfg_data[KEY_W-1:0];
                REG_GUEST_SEL:     cfg_reg.guest_select_key <= cfg_data[KEY_W-1:0];
                REG_FAIL_LIMIT:    cfg_reg.fail_limit       <= cfg_data[TRIES_W-1:0];
                REG_BLOCK_TICKS:   cfg_reg.block_ticks      <= cfg_data[TICKS_W-1:0];
                REG_START_BLOCKED: ;   // start-up lock flag acts through lock_load
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.action <= s_tuser;
            in_item_reg.key    <= s_tdata;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    kppl_core #(
        .PIN_LENGTH (PIN_LENGTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .run       (advance),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .lock_load (lock_load),
        .res       (res)
    );

endmodule

`default_nettype wire

### sv/kppl_checker.sv
`default_nettype none

`include "assert_macros.svh"

module kppl_checker
    import kppl_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [15:0]       m_tdata,
    input wire logic [2:0]        m_tuser
);

    logic [ROLE_W-1:0]  role;
    logic [TRIES_W-1:0] left;
    logic [DIGIT_W-1:0] digits;
    logic               has_role;
    logic               granted;
    logic               wrong_pin;
    logic               digit_taken;
    logic               stalled;
    logic [18:0]        out_word;

    assign role        = m_tdata[1:0];
    assign left        = m_tdata[5:2];
    assign digits      = m_tdata[8:6];
    assign has_role    = m_tvalid && (role != ROLE_NONE);
    assign granted     = m_tvalid && (m_tuser == ST_GRANTED);
    assign wrong_pin   = m_tvalid && (m_tuser == ST_WRONG_PIN);
    assign digit_taken = m_tvalid && (m_tuser == ST_DIGIT);
    assign stalled     = m_tvalid && !m_tready;
    assign out_word    = {m_tuser, m_tdata};

    `KPPL_ASSERT(a_role_only_granted, has_role |-> granted, "role without grant")
    `KPPL_ASSERT(a_granted_clears, granted |-> has_role && digits == 3'd0, "bad grant fields")
    `KPPL_ASSERT(a_wrong_pin_left, wrong_pin |-> left != 4'd0 && digits == 3'd0, "bad wrong pin")
    `KPPL_ASSERT(a_digit_count, digit_taken |-> digits != 3'd0, "digit taken with zero count")
    `KPPL_ASSERT(a_out_hold, stalled |=> m_tvalid && $stable(out_word), "stalled result changed")

endmodule

bind keypad_pin_lock_with_lockout kppl_checker u_kppl_checker (.*);

`default_nettype wire

### dv/keypad_pin_lock_with_lockout_tb.sv
`timescale 1ns / 1ps

module keypad_pin_lock_with_lockout_tb;
    import kppl_pkg::*;

    localparam int PIN_LEN = 4;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [KEY_W-1:0]   s_tdata;    // key
    logic               s_tuser;    // action
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;    // granted_role, tries_left, digits_entered, zeros
    logic [2:0]         m_tuser;    // status
    logic               cfg_valid;
    logic               cfg_ready;
    reg_idx_t           cfg_index;
    logic [PIN_W-1:0]   cfg_data;

    // lock model state
    cfg_t               lk_cfg;
    phase_t             lk_phase;
    logic               lk_role;        // 0 admin, 1 guest
    logic [DIGIT_W-1:0] lk_digits;
    logic [PIN_W-1:0]   lk_entered;
    logic [TRIES_W-1:0] lk_fails;
    logic [TICKS_W-1:0] lk_countdown;

    res_t expected_results[$];
    int   mismatch_count = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;

    keypad_pin_lock_with_lockout #(.PIN_LENGTH(PIN_LEN)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void begin_lockout();
        lk_phase     = PH_LOCKED;
        lk_countdown = lk_cfg.block_ticks;
        lk_digits    = '0;
        lk_entered   = '0;
    endfunction

    function automatic void reset_lock_model();
        lk_cfg.admin_pin        = '0;
        lk_cfg.guest_pin        = '0;
        lk_cfg.admin_select_key = 8'd48;
        lk_cfg.guest_select_key = 8'd49;
        lk_cfg.fail_limit       = 4'd3;
        lk_cfg.block_ticks      = 16'd20000;
        lk_phase                = PH_SELECT;
        lk_role                 = 1'b0;
        lk_digits               = '0;
        lk_entered              = '0;
        lk_fails                = '0;
        lk_countdown            = '0;
    endfunction

    function automatic void apply_reg_write(input reg_idx_t idx, input logic [PIN_W-1:0] val);
        case (idx)
            REG_ADMIN_PIN:     lk_cfg.admin_pin = val;
            REG_GUEST_PIN:     lk_cfg.guest_pin = val;
            REG_ADMIN_SEL:     lk_cfg.admin_select_key = val[KEY_W-1:0];
            REG_GUEST_SEL:     lk_cfg.guest_select_key = val[KEY_W-1:0];
            REG_FAIL_LIMIT:    lk_cfg.fail_limit = val[TRIES_W-1:0];
            REG_BLOCK_TICKS:   lk_cfg.block_ticks = val[TICKS_W-1:0];
            REG_START_BLOCKED:
            begin
                if (val[0])
                    begin_lockout();
            end
            default: ;
        endcase
    endfunction

    function automatic res_t lock_response(input logic act, input logic [KEY_W-1:0] k);
        res_t        r;
        logic [63:0] mask;
        logic [63:0] want;
        r.status       = ST_NONE;
        r.granted_role = ROLE_NONE;
        if (act)
        begin
            if (lk_phase == PH_LOCKED)
            begin
                if (lk_countdown <= 16'd1)
                begin
                    lk_countdown = '0;
                    lk_fails     = '0;
                    lk_phase     = PH_SELECT;
                    r.status     = ST_LOCK_END;
                end
                else
                    lk_countdown = lk_countdown - 16'd1;
            end
        end
        else if (lk_phase == PH_LOCKED)
            r.status = ST_LOCKED;
        else if (lk_phase == PH_SELECT)
        begin
            if (k == lk_cfg.admin_select_key || k == lk_cfg.guest_select_key)
            begin
                lk_role    = (k != lk_cfg.admin_select_key);
                lk_phase   = PH_ENTRY;
                lk_digits  = '0;
                lk_entered = '0;
                r.status   = ST_ROLE;
            end
            else
                r.status = ST_WRONG_SEL;
        end
        else
        begin
            lk_entered[8*lk_digits[1:0] +: 8] = k;
            lk_digits = lk_digits + 3'd1;
            r.status  = ST_DIGIT;
            if (lk_digits >= PIN_LEN)
            begin
                mask = (64'd1 << (8 * PIN_LEN)) - 64'd1;
                want = {32'd0, lk_role ? lk_cfg.guest_pin : lk_cfg.admin_pin};
                lk_digits = '0;
                if ((({32'd0, lk_entered} ^ want) & mask) == 64'd0)
                begin
                    lk_fails       = '0;
                    lk_phase       = PH_SELECT;
                    r.status       = ST_GRANTED;
                    r.granted_role = lk_role ? ROLE_GUEST : ROLE_ADMIN;
                end
                else
                begin
                    lk_fails = lk_fails + 4'd1;
                    if (lk_fails >= lk_cfg.fail_limit)
                    begin
                        begin_lockout();
                        r.status = ST_LOCKED;
                    end
                    else
                        r.status = ST_WRONG_PIN;
                end
                lk_entered = '0;
            end
        end
        r.tries_left     = (lk_fails >= lk_cfg.fail_limit) ? 4'd0
                                                          : lk_cfg.fail_limit - lk_fails;
        r.digits_entered = lk_digits;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // called at a falling edge; leaves tvalid high for a back-to-back request
    task automatic send_event(input logic act, input logic [KEY_W-1:0] k);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= k;
        do @(posedge clk); while (!s_tready);
        expected_results.push_back(lock_response(act, k));
        @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [PIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg_write(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status         = status_t'(m_tuser);
            got.granted_role   = m_tdata[1:0];
            got.tries_left     = m_tdata[5:2];
            got.digits_entered = m_tdata[8:6];
            if (expected_results.size() == 0)
                flag_error($sformatf("unexpected result status=%0d role=%0d left=%0d digits=%0d",
                           got.status, got.granted_role, got.tries_left, got.digits_entered));
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.granted_role !== want.granted_role ||
                    got.tries_left !== want.tries_left ||
                    got.digits_entered !== want.digits_entered)
                    flag_error($sformatf({"mismatch exp status=%0d role=%0d left=%0d digits=%0d",
                               " got status=%0d role=%0d left=%0d digits=%0d"},
                               want.status, want.granted_role, want.tries_left,
                               want.digits_entered, got.status, got.granted_role,
                               got.tries_left, got.digits_entered));
            end
        end
    end

    task automatic test_defaults();
        send_event(1'b0, 8'hAB);
        send_event(1'b1, 8'h30);
        send_event(1'b0, 8'd49);
        repeat (4) send_event(1'b0, 8'h00);
    endtask

    task automatic test_pin_extremes();
        wait_until_drained();
        write_reg(REG_ADMIN_PIN, 32'hFFFF_FFFF);
        write_reg(REG_GUEST_PIN, 32'h0403_0201);
        write_reg(REG_ADMIN_SEL, 32'h0000_0000);
        write_reg(REG_GUEST_SEL, 32'h0000_00FF);
        write_reg(REG_FAIL_LIMIT, 32'd9);
        send_event(1'b0, 8'hFF);
        for (int i = 1; i <= 4; i++)
            send_event(1'b0, 8'(i));
        send_event(1'b0, 8'h00);
        send_event(1'b0, 8'hFF);
        send_event(1'b0, 8'hFF);
        send_event(1'b0, 8'hFF);
        send_event(1'b0, 8'h00);
    endtask

    // zero tries allowed and zero lock length, then equal select codes
    task automatic test_lockout_limits();
        wait_until_drained();
        write_reg(REG_FAIL_LIMIT, 32'd0);
        write_reg(REG_BLOCK_TICKS, 32'd0);
        write_reg(REG_GUEST_SEL, 32'h0000_0000);
        for (int i = 1; i <= 4; i++)
            send_event(1'b0, 8'(i));
        send_event(1'b0, 8'h30);
        send_event(1'b1, 8'h00);
        send_event(1'b0, 8'h00);
    endtask

    // lock flag at start-up drops a partial attempt
    task automatic test_start_blocked();
        send_event(1'b0, 8'hFF);
        wait_until_drained();
        write_reg(REG_BLOCK_TICKS, 32'd65535);
        write_reg(REG_START_BLOCKED, 32'd1);
        send_event(1'b1, 8'hFF);
        send_event(1'b0, 8'h00);
        wait_until_drained();
        write_reg(REG_BLOCK_TICKS, 32'd2);
        write_reg(REG_START_BLOCKED, 32'd1);
        send_event(1'b1, 8'h55);
        send_event(1'b1, 8'hAA);
        wait_until_drained();
        write_reg(REG_START_BLOCKED, 32'd0);
        write_reg(REG_FAIL_LIMIT, 32'd1);
        send_event(1'b0, 8'h00);
        repeat (4) send_event(1'b0, 8'hFF);
    endtask

    task automatic load_random_setup();
        logic [KEY_W-1:0] a_sel;
        a_sel = 8'($urandom_range(255));
        write_reg(REG_ADMIN_PIN, $urandom());
        write_reg(REG_GUEST_PIN, $urandom());
        write_reg(REG_ADMIN_SEL, {24'd0, a_sel});
        write_reg(REG_GUEST_SEL, ($urandom_range(9) == 0) ? {24'd0, a_sel}
                                                          : 32'($urandom_range(255)));
        write_reg(REG_FAIL_LIMIT, 32'($urandom_range(1, 9)));
        write_reg(REG_BLOCK_TICKS, 32'($urandom_range(1, 6)));
        write_reg(REG_START_BLOCKED, ($urandom_range(3) == 0) ? 32'd1 : 32'd0);
    endtask

    task automatic send_random_event();
        int               roll;
        logic [PIN_W-1:0] pin;
        logic [KEY_W-1:0] k;
        roll = $urandom_range(99);
        k    = 8'($urandom_range(255));
        case (lk_phase)
            PH_LOCKED:
                send_event(roll < 80, k);
            PH_SELECT:
            begin
                if (roll < 70)
                    send_event(1'b0, $urandom_range(1) ? lk_cfg.admin_select_key
                                                       : lk_cfg.guest_select_key);
                else
                    send_event(roll < 82, k);
            end
            default:
            begin
                pin = lk_role ? lk_cfg.guest_pin : lk_cfg.admin_pin;
                if (roll < 6)
                    send_event(1'b1, k);
                else
                    send_event(1'b0, (roll < 85) ? pin[8*lk_digits[1:0] +: 8] : k);
            end
        endcase
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int n_events, input bit pause_midway);
        wait_until_drained();
        send_idle_pct = sender_pct;
        stall_pct     = receiver_pct;
        load_random_setup();
        for (int i = 0; i < n_events; i++)
        begin
            if (pause_midway && i == n_events / 2)
                wait_until_drained();
            send_random_event();
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ADMIN_PIN;
        cfg_data  = '0;
        reset_lock_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_defaults();
        test_pin_extremes();
        test_lockout_limits();
        test_start_blocked();
        test_random_traffic(0, 0, 315, 1'b1);
        test_random_traffic(62, 0, 315, 1'b0);
        test_random_traffic(0, 62, 315, 1'b0);
        test_random_traffic(33, 33, 315, 1'b1);

        wait_until_drained();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/kppl_pkg.sv
sv/kppl_core.sv
sv/keypad_pin_lock_with_lockout.sv
sv/kppl_checker.sv
dv/keypad_pin_lock_with_lockout_tb.sv
